### rtl/cdtp_pkg.sv
// Package: types, constants and CRC helper for the CD-Text pack framer.
`timescale 1ns / 1ps
`default_nettype none
package cdtp_pkg;

    localparam int TEXT_BYTES_PER_PACK = 12;
    localparam int HDR_LEN             = 4;
    localparam int PACK_LEN            = 18;
    localparam int CRC_POS             = HDR_LEN + TEXT_BYTES_PER_PACK;
    localparam int INFO_PACKS          = 3;

    localparam int FILL_W = $clog2(TEXT_BYTES_PER_PACK + 1);
    localparam int BIDX_W = $clog2(TEXT_BYTES_PER_PACK);
    localparam int BYTE_W = $clog2(PACK_LEN);
    localparam int PIDX_W = $clog2(INFO_PACKS);

    localparam logic [BYTE_W-1:0] BYTE_SEQ     = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] BYTE_POS     = BYTE_W'(3);
    localparam logic [BYTE_W-1:0] BYTE_CRC_HI  = BYTE_W'(CRC_POS);
    localparam logic [BYTE_W-1:0] BYTE_CRC_LO  = BYTE_W'(CRC_POS + 1);
    localparam logic [PIDX_W-1:0] LAST_INFO    = PIDX_W'(INFO_PACKS - 1);

    localparam logic       OP_TEXT   = 1'b0;
    localparam logic       OP_FINISH = 1'b1;

    localparam logic       REG_FIRST_TRACK = 1'b0;
    localparam logic       REG_LAST_TRACK  = 1'b1;

    localparam logic [7:0]  TYPE_TITLE     = 8'h80;
    localparam logic [7:0]  TYPE_PERFORMER = 8'h81;
    localparam logic [7:0]  TYPE_SIZE_INFO = 8'h8F;
    localparam logic [7:0]  LANG_ENGLISH   = 8'h09;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    typedef struct packed {
        logic       opcode;
        logic [7:0] text_byte;
        logic [7:0] pack_type;
        logic [6:0] track_number;
        logic       end_of_block;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_pack;
        logic       last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_INFO
    } t_state;

    typedef struct packed {
        logic              load_char;   // text item accepted
        logic              info;        // emitting size-information packs
        logic              byte_adv;    // current byte taken by receiver
        logic              pack_end;    // last byte of a pack taken
        logic              run_end;     // last byte of the run taken
        logic              last_of_run; // current byte ends the run
        logic [BYTE_W-1:0] byte_idx;
        logic [PIDX_W-1:0] pack_idx;
    } t_cmd;

    typedef struct packed {
        logic pack_done;                // accepted char completes a pack
    } t_status;

    // MSB-first CRC-16 CCITT, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
        logic [15:0] c;
        c = crc_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/cdtp_ctrl.sv
// Controller: handshake, byte/pack sequencing for the pack framer.
`timescale 1ns / 1ps
`default_nettype none
module cdtp_ctrl
    import cdtp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_opcode,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_cmd         o_cmd
);

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [PIDX_W-1:0] r_pack, n_pack;
    logic              accept;
    logic              adv;
    logic              at_last_byte;

    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign adv          = (r_state != ST_IDLE) && i_out_ready;
    assign at_last_byte = (r_byte == BYTE_CRC_LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_byte  <= '0;
            r_pack  <= '0;
        end else begin
            r_state <= n_state;
            r_byte  <= n_byte;
            r_pack  <= n_pack;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_FINISH) begin
                        n_state = ST_INFO;
                    end else if (i_status.pack_done) begin
                        n_state = ST_TEXT;
                    end
                end
            end
            ST_TEXT: begin
                if (adv && at_last_byte) begin
                    n_state = ST_IDLE;
                end
            end
            ST_INFO: begin
                if (adv && at_last_byte && (r_pack == LAST_INFO)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_byte = r_byte;
        n_pack = r_pack;
        if (accept) begin
            n_byte = '0;
            n_pack = '0;
        end else if (adv) begin
            if (at_last_byte) begin
                n_byte = '0;
                n_pack = r_pack + PIDX_W'(1);
            end else begin
                n_byte = r_byte + BYTE_W'(1);
            end
        end
    end

    // outputs
    always_comb begin
        o_in_ready        = 1'b0;
        o_out_valid       = 1'b0;
        o_cmd             = '0;
        o_cmd.byte_idx    = r_byte;
        o_cmd.pack_idx    = r_pack;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_char = i_in_valid && (i_opcode == OP_TEXT);
            end
            ST_TEXT: begin
                o_out_valid       = 1'b1;
                o_cmd.byte_adv    = i_out_ready;
                o_cmd.pack_end    = i_out_ready && at_last_byte;
                o_cmd.run_end     = i_out_ready && at_last_byte;
                o_cmd.last_of_run = at_last_byte;
            end
            ST_INFO: begin
                o_out_valid       = 1'b1;
                o_cmd.info        = 1'b1;
                o_cmd.byte_adv    = i_out_ready;
                o_cmd.pack_end    = i_out_ready && at_last_byte;
                o_cmd.run_end     = i_out_ready && at_last_byte && (r_pack == LAST_INFO);
                o_cmd.last_of_run = at_last_byte && (r_pack == LAST_INFO);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/cdtp_datapath.sv
// Datapath: text buffer, header/counter state, pack byte mux and CRC.
`timescale 1ns / 1ps
`default_nettype none
module cdtp_datapath
    import cdtp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_in_item   i_item,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    output t_status         o_status,
    output t_out_item       o_item
);

    logic [7:0]        r_body [TEXT_BYTES_PER_PACK];
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_hdr_type;
    logic [6:0]        r_hdr_track;
    logic [7:0]        r_hdr_pos;
    logic [7:0]        r_char_pos;
    logic [7:0]        r_seq;
    logic [7:0]        r_title_cnt;
    logic [7:0]        r_perf_cnt;
    logic [15:0]       r_crc;
    logic [6:0]        r_first_track;
    logic [6:0]        r_last_track;

    logic [BYTE_W-1:0] body_off;
    logic [BIDX_W-1:0] body_idx;
    logic [7:0]        text_byte;
    logic [7:0]        info_byte;
    logic [7:0]        cur_byte;
    logic [7:0]        seq_plus;

    assign o_status.pack_done = (r_fill == FILL_W'(TEXT_BYTES_PER_PACK - 1))
                                || i_item.end_of_block;

    // body is only written, never cleared: slots at or past the fill count read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_body[r_fill[BIDX_W-1:0]] <= i_item.text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill        <= '0;
            r_hdr_type    <= '0;
            r_hdr_track   <= '0;
            r_hdr_pos     <= '0;
            r_char_pos    <= '0;
            r_seq         <= '0;
            r_title_cnt   <= '0;
            r_perf_cnt    <= '0;
            r_crc         <= '0;
            r_first_track <= 7'd1;
            r_last_track  <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FIRST_TRACK) begin
                    r_first_track <= i_cfg_data;
                end else begin
                    r_last_track <= i_cfg_data;
                end
            end
            if (i_cmd.load_char) begin
                if (r_fill == '0) begin
                    r_hdr_type  <= i_item.pack_type;
                    r_hdr_track <= i_item.track_number;
                    r_hdr_pos   <= r_char_pos;
                end
                r_fill <= r_fill + FILL_W'(1);
                if (i_item.end_of_block || (i_item.text_byte == 8'h00)) begin
                    r_char_pos <= '0;
                end else begin
                    r_char_pos <= r_char_pos + 8'd1;
                end
            end
            if (i_cmd.pack_end) begin
                r_crc <= '0;
            end else if (i_cmd.byte_adv && (i_cmd.byte_idx < BYTE_CRC_HI)) begin
                r_crc <= crc_byte(r_crc, cur_byte);
            end
            if (i_cmd.pack_end && !i_cmd.info) begin
                r_fill <= '0;
                r_seq  <= r_seq + 8'd1;
                if (r_hdr_type == TYPE_TITLE) begin
                    r_title_cnt <= r_title_cnt + 8'd1;
                end else if (r_hdr_type == TYPE_PERFORMER) begin
                    r_perf_cnt <= r_perf_cnt + 8'd1;
                end
            end
            if (i_cmd.run_end && i_cmd.info) begin
                r_fill      <= '0;
                r_seq       <= '0;
                r_title_cnt <= '0;
                r_perf_cnt  <= '0;
                r_char_pos  <= '0;
            end
        end
    end

    assign body_off = i_cmd.byte_idx - BYTE_W'(HDR_LEN);
    assign body_idx = body_off[BIDX_W-1:0];
    assign seq_plus = r_seq + {{(8-PIDX_W){1'b0}}, i_cmd.pack_idx};

    always_comb begin
        text_byte = 8'h00;
        case (i_cmd.byte_idx)
            BYTE_W'(0): text_byte = r_hdr_type;
            BYTE_W'(1): text_byte = {1'b0, r_hdr_track};
            BYTE_SEQ:   text_byte = r_seq;
            BYTE_POS:   text_byte = r_hdr_pos;
            default: begin
                if (FILL_W'(body_idx) < r_fill) begin
                    text_byte = r_body[body_idx];
                end
            end
        endcase
    end

    // size-information layout: counts in pack 0, pack total and last
    // sequence number in pack 1, language code in pack 2
    always_comb begin
        info_byte = 8'h00;
        case (i_cmd.byte_idx)
            BYTE_W'(0): info_byte = TYPE_SIZE_INFO;
            BYTE_W'(1): info_byte = {{(8-PIDX_W){1'b0}}, i_cmd.pack_idx};
            BYTE_SEQ:   info_byte = seq_plus;
            BYTE_W'(5): if (i_cmd.pack_idx == PIDX_W'(0)) info_byte = {1'b0, r_first_track};
            BYTE_W'(6): if (i_cmd.pack_idx == PIDX_W'(0)) info_byte = {1'b0, r_last_track};
            BYTE_W'(7): if (i_cmd.pack_idx == PIDX_W'(1)) info_byte = 8'(INFO_PACKS);
            BYTE_W'(8): begin
                if (i_cmd.pack_idx == PIDX_W'(0)) begin
                    info_byte = r_title_cnt;
                end else if (i_cmd.pack_idx == PIDX_W'(2)) begin
                    info_byte = LANG_ENGLISH;
                end
            end
            BYTE_W'(9): if (i_cmd.pack_idx == PIDX_W'(0)) info_byte = r_perf_cnt;
            BYTE_W'(12): if (i_cmd.pack_idx == PIDX_W'(1)) info_byte = r_seq + 8'd2;
            default: info_byte = 8'h00;
        endcase
    end

    always_comb begin
        if (i_cmd.byte_idx == BYTE_CRC_HI) begin
            cur_byte = ~r_crc[15:8];
        end else if (i_cmd.byte_idx == BYTE_CRC_LO) begin
            cur_byte = ~r_crc[7:0];
        end else if (i_cmd.info) begin
            cur_byte = info_byte;
        end else begin
            cur_byte = text_byte;
        end
    end

    assign o_item.out_byte     = cur_byte;
    assign o_item.last_of_pack = (i_cmd.byte_idx == BYTE_CRC_LO);
    assign o_item.last_of_run  = i_cmd.last_of_run;

endmodule
`default_nettype wire

### rtl/cd_text_pack_framer_unit.sv
// Top level: CD-Text pack framer with CRC-16 CCITT.
//
// Input channel (i_in_valid / o_in_ready, i_in_item) takes one item at a time:
// a text character or a finish command. A character that does not close a
// pack is absorbed and produces nothing. A character that fills the twelfth
// text slot or carries end_of_block starts an 18-byte pack on the output
// channel; a finish command starts three size-information packs (54 bytes).
// Output (o_out_valid / i_out_ready, o_out_item) moves one byte per cycle
// while the receiver is ready; the first byte is valid the cycle after the
// input is accepted, and the CRC is built byte by byte as the pack goes out.
// While bytes are being sent no input is taken; the single output path is
// one byte wide. A stalled receiver simply holds the current byte.
// The config channel (i_cfg_valid / o_cfg_ready) is always ready and writes
// first_track (index 0) or last_track (index 1).
// Reset (synchronous, active low) clears all counters and the pending pack,
// first_track returns to 1 and last_track to 0; the block is ready at once.
`timescale 1ns / 1ps
`default_nettype none
module cd_text_pack_framer_unit
    import cdtp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_index,
    input  wire logic [6:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    cdtp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_item.opcode),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    cdtp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_item      (o_out_item)
    );

    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a pack is being sent");

    a_run_ends_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last_of_run) |-> o_out_item.last_of_pack)
        else $error("run ends mid-pack");

    a_ready_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.last_of_run) |=> o_in_ready)
        else $error("not ready after last byte of run");

    a_pack_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_item.last_of_pack && !o_out_item.last_of_run)
        |=> o_out_valid)
        else $error("size-information run broke off between packs");

endmodule
`default_nettype wire
